// ===== rtl/core/icf_pkg.sv =====
`default_nettype none

package icf_pkg;

  localparam int PIX_W     = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = PIX_W + COEF_W;
  localparam int SUM_W     = 35;
  localparam int DIM_W     = 12;
  localparam int KSIZE_W   = 3;
  localparam int CFG_W     = 64;
  localparam int TAP_REGS  = 7;
  localparam int TAPS_HI_W = 48;
  localparam int REG_IDX_W = 3;

  localparam int DEF_MAX_WIDTH  = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam int DEF_MAX_TAPS   = 7;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [DIM_W-1:0]   RST_WIDTH  = 12'd640;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 12'd480;
  localparam logic [KSIZE_W-1:0] RST_KSIZE  = 3'd3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_KERNEL_SIZE,
    REG_TAPS_LOW,
    REG_TAPS_HIGH
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [KSIZE_W-1:0] ksize;
  } icf_geom_t;

endpackage

`default_nettype wire

// ===== rtl/core/image_column_fir_filter_top.sv =====
// Path: input register, queue, then product, sum and output registers.
// Throughput: one pixel per cycle, set by the six line stores read in parallel and
// the tap multipliers, while the queue has room; border rows give no result beat.
// Reset: position counters cleared, registers to 640x480, 3 taps, all taps zero.
// Line stores are not cleared; no result beat uses an unwritten entry.
`default_nettype none

module image_column_fir_filter_top #(
  parameter int MAX_WIDTH  = icf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = icf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_TAPS   = icf_pkg::DEF_MAX_TAPS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 write_enable,
  input  logic [icf_pkg::REG_IDX_W-1:0]        register_index,
  input  logic [icf_pkg::CFG_W-1:0]            write_data,
  input  logic                                 pixel_valid,
  output logic                                 pixel_ready,
  input  logic signed [icf_pkg::PIX_W-1:0]     pixel_value,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [icf_pkg::SUM_W-1:0]     filtered_value,
  output logic [$clog2(MAX_HEIGHT)-1:0]        out_row,
  output logic [$clog2(MAX_WIDTH)-1:0]         out_column,
  output logic                                 frame_end
);
  import icf_pkg::*;

  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int DATA_W = MAX_TAPS * PIX_W + ROW_W + COL_W + 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  icf_geom_t                      geom;
  logic [CFG_W-1:0]               taps_lo;
  logic [TAPS_HI_W-1:0]           taps_hi;
  logic                           push;
  logic [DATA_W-1:0]              push_data;
  logic                           pop;
  logic [DATA_W-1:0]              head_data;
  logic                           not_empty;
  logic [CNT_W-1:0]               q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.width  <= RST_WIDTH;
      geom.height <= RST_HEIGHT;
      geom.ksize  <= RST_KSIZE;
      taps_lo     <= '0;
      taps_hi     <= '0;
    end else if (write_enable) begin
      case (cfg_reg_t'(register_index))
        REG_IMAGE_WIDTH:  geom.width  <= write_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: geom.height <= write_data[DIM_W-1:0];
        REG_KERNEL_SIZE:  geom.ksize  <= write_data[KSIZE_W-1:0];
        REG_TAPS_LOW:     taps_lo     <= write_data;
        REG_TAPS_HIGH:    taps_hi     <= write_data[TAPS_HI_W-1:0];
        default: ;
      endcase
    end
  end

  icf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_TAPS   (MAX_TAPS),
    .DEPTH      (QUEUE_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .geom        (geom),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel_value (pixel_value),
    .q_count     (q_count),
    .push        (push),
    .push_data   (push_data)
  );

  icf_queue #(
    .DATA_W (DATA_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head_data (head_data),
    .not_empty (not_empty),
    .count     (q_count)
  );

  icf_back #(
    .MAX_TAPS (MAX_TAPS),
    .ROW_W    (ROW_W),
    .COL_W    (COL_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (not_empty),
    .q_data         (head_data),
    .pop            (pop),
    .taps           ({taps_hi, taps_lo}),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .filtered_value (filtered_value),
    .out_row        (out_row),
    .out_column     (out_column),
    .frame_end      (frame_end)
  );

endmodule

`default_nettype wire

// ===== rtl/core/icf_queue.sv =====
`default_nettype none

module icf_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic [DATA_W-1:0]           push_data,
  input  logic                        pop,
  output logic [DATA_W-1:0]           head_data,
  output logic                        not_empty,
  output logic [$clog2(DEPTH+1)-1:0]  count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (!push && pop) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign head_data = slots[rd_ptr];
  assign not_empty = (count != '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> count < CNT_W'(DEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue underflow");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("queue count lost a beat");

endmodule

`default_nettype wire

// ===== rtl/core/icf_front.sv =====
`default_nettype none

module icf_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int MAX_TAPS   = 7,
  parameter int DEPTH      = 4
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  icf_pkg::icf_geom_t                       geom,
  input  logic                                     pixel_valid,
  output logic                                     pixel_ready,
  input  logic signed [icf_pkg::PIX_W-1:0]         pixel_value,
  input  logic [$clog2(DEPTH+1)-1:0]               q_count,
  output logic                                     push,
  output logic [MAX_TAPS*icf_pkg::PIX_W+$clog2(MAX_HEIGHT)+$clog2(MAX_WIDTH):0] push_data
);
  import icf_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int CW1    = COL_W + 1;
  localparam int RW1    = ROW_W + 1;
  localparam int TAP_W  = $clog2(MAX_TAPS + 1);
  localparam int LINES  = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int IDX_W  = $clog2(2 * LINES + 1);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [COL_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic [SLOT_W-1:0] slot_cnt;

  logic [CW1-1:0]    w_eff;
  logic [RW1-1:0]    h_eff;
  logic [TAP_W-1:0]  s_eff;
  logic [TAP_W-1:0]  s_m1;
  logic [TAP_W-1:0]  row_off;
  logic              col_wrap;
  logic              row_wrap;
  logic [RW1-1:0]    row_a;
  logic [SLOT_W-1:0] slot_a;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [SLOT_W-1:0] slot_cur;
  logic [CW1-1:0]    col_nx;
  logic [RW1-1:0]    row_nx;
  logic              produce;
  logic              accept;

  logic [PIX_W-1:0]  rd [LINES];

  logic              f1_valid;
  logic [PIX_W-1:0]  f1_pix;
  logic [SLOT_W-1:0] f1_slot;
  logic [TAP_W-1:0]  f1_sm1;
  logic [ROW_W-1:0]  f1_row;
  logic [COL_W-1:0]  f1_col;
  logic              f1_end;
  logic [MAX_TAPS*PIX_W-1:0] window;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(LINES - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  always_comb begin
    if (geom.width == '0)                 w_eff = CW1'(1);
    else if (32'(geom.width) > MAX_WIDTH) w_eff = CW1'(MAX_WIDTH);
    else                                  w_eff = CW1'(geom.width);
    if (geom.height == '0)                  h_eff = RW1'(1);
    else if (32'(geom.height) > MAX_HEIGHT) h_eff = RW1'(MAX_HEIGHT);
    else                                    h_eff = RW1'(geom.height);
    s_eff = (32'(geom.ksize) > MAX_TAPS) ? TAP_W'(MAX_TAPS) : TAP_W'(geom.ksize);
    s_m1    = s_eff - TAP_W'(1);
    row_off = s_m1 - (s_m1 >> 1);

    // counts beyond a shrunk frame roll to the next row / frame first
    col_wrap = ({1'b0, col_cnt} >= w_eff);
    row_a    = col_wrap ? {1'b0, row_cnt} + RW1'(1) : {1'b0, row_cnt};
    slot_a   = col_wrap ? slot_inc(slot_cnt) : slot_cnt;
    row_wrap = (row_a >= h_eff);
    col_cur  = col_wrap ? '0 : col_cnt;
    row_cur  = row_wrap ? '0 : row_a[ROW_W-1:0];
    slot_cur = row_wrap ? '0 : slot_a;

    col_nx  = {1'b0, col_cur} + CW1'(1);
    row_nx  = {1'b0, row_cur} + RW1'(1);
    produce = (s_eff != '0) && ({1'b0, row_cur} >= RW1'(s_m1));
  end

  assign pixel_ready = ({1'b0, q_count} + (CNT_W + 1)'(f1_valid)) < (CNT_W + 1)'(DEPTH);
  assign accept      = pixel_valid && pixel_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      slot_cnt <= '0;
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept && produce;
      if (accept) begin
        if (col_nx >= w_eff) begin
          col_cnt <= '0;
          if (row_nx >= h_eff) begin
            row_cnt  <= '0;
            slot_cnt <= '0;
          end else begin
            row_cnt  <= row_nx[ROW_W-1:0];
            slot_cnt <= slot_inc(slot_cur);
          end
        end else begin
          col_cnt  <= col_nx[COL_W-1:0];
          row_cnt  <= row_cur;
          slot_cnt <= slot_cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_pix  <= pixel_value;
      f1_slot <= slot_cur;
      f1_sm1  <= s_m1;
      f1_row  <= row_cur - ROW_W'(row_off);
      f1_col  <= col_cur;
      f1_end  <= ({1'b0, row_cur} == h_eff - RW1'(1)) &&
                 ({1'b0, col_cur} == w_eff - CW1'(1));
    end
  end

  // one line store per row slot; read of the old entry precedes its overwrite
  for (genvar j = 0; j < LINES; j++) begin : g_line
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (accept) begin
        if (slot_cur == SLOT_W'(j)) mem[col_cur] <= pixel_value;
        rd[j] <= mem[col_cur];
      end
    end
  end

  always_comb begin
    logic [TAP_W-1:0] d;
    logic [IDX_W-1:0] idx;
    window = '0;
    d      = '0;
    idx    = '0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      if (TAP_W'(k) < f1_sm1) begin
        d = f1_sm1 - TAP_W'(k);
        if (f1_slot >= SLOT_W'(d)) idx = IDX_W'(f1_slot) - IDX_W'(d);
        else idx = IDX_W'(f1_slot) + IDX_W'(LINES) - IDX_W'(d);
        window[k*PIX_W +: PIX_W] = rd[idx[SLOT_W-1:0]];
      end else if (TAP_W'(k) == f1_sm1) begin
        window[k*PIX_W +: PIX_W] = f1_pix;
      end
    end
  end

  assign push      = f1_valid;
  assign push_data = {window, f1_row, f1_col, f1_end};

  a_accept_has_room: assert property (@(posedge clk) disable iff (rst)
    accept |-> q_count < CNT_W'(DEPTH))
    else $error("pixel taken with no queue room");

  a_push_follows_beat: assert property (@(posedge clk) disable iff (rst)
    push |-> $past(accept))
    else $error("push without an accepted beat");

  a_counts_in_frame: assert property (@(posedge clk) disable iff (rst)
    accept |=> {1'b0, col_cnt} < $past(w_eff) && {1'b0, row_cnt} < $past(h_eff))
    else $error("position counters left the frame");

endmodule

`default_nettype wire

// ===== rtl/core/icf_back.sv =====
`default_nettype none

module icf_back #(
  parameter int MAX_TAPS = 7,
  parameter int ROW_W    = 11,
  parameter int COL_W    = 11
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        q_valid,
  input  logic [MAX_TAPS*icf_pkg::PIX_W+ROW_W+COL_W:0] q_data,
  output logic                                        pop,
  input  logic [icf_pkg::TAP_REGS*icf_pkg::COEF_W-1:0] taps,
  output logic                                        result_valid,
  input  logic                                        result_ready,
  output logic signed [icf_pkg::SUM_W-1:0]            filtered_value,
  output logic [ROW_W-1:0]                            out_row,
  output logic [COL_W-1:0]                            out_column,
  output logic                                        frame_end
);
  import icf_pkg::*;

  localparam int TAG_W = ROW_W + COL_W + 1;
  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS) + 1;
  localparam int NPAIR = (MAX_TAPS + 1) / 2;

  logic signed [COEF_W-1:0] coef [MAX_TAPS];
  logic signed [PIX_W-1:0]  win  [MAX_TAPS];

  logic                     p_valid, s_valid, o_valid;
  logic                     p_ready, s_ready, o_ready;
  logic signed [PROD_W-1:0] prod [MAX_TAPS];
  logic [TAG_W-1:0]         p_tag, s_tag;
  logic signed [ACC_W-1:0]  psum [NPAIR];
  logic signed [ACC_W-1:0]  total;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    if (k < TAP_REGS) begin : g_used
      assign coef[k] = taps[k*COEF_W +: COEF_W];
    end else begin : g_zero
      assign coef[k] = '0;
    end
    assign win[k] = q_data[TAG_W + k*PIX_W +: PIX_W];
  end

  assign o_ready = !o_valid || result_ready;
  assign s_ready = !s_valid || o_ready;
  assign p_ready = !p_valid || s_ready;
  assign pop     = q_valid && p_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      s_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (p_ready) p_valid <= q_valid;
      if (s_ready) s_valid <= p_valid;
      if (o_ready) o_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int k = 0; k < MAX_TAPS; k++) prod[k] <= coef[k] * win[k];
      p_tag <= q_data[TAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (p_valid && s_ready) begin
      for (int i = 0; i < NPAIR; i++) begin
        if (2 * i + 1 < MAX_TAPS) psum[i] <= ACC_W'(prod[2*i]) + ACC_W'(prod[2*i+1]);
        else psum[i] <= ACC_W'(prod[2*i]);
      end
      s_tag <= p_tag;
    end
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < NPAIR; i++) total = total + psum[i];
  end

  always_ff @(posedge clk) begin
    if (s_valid && o_ready) begin
      filtered_value <= SUM_W'(total);
      {out_row, out_column, frame_end} <= s_tag;
    end
  end

  assign result_valid = o_valid;

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid && (!p_valid || s_ready))
    else $error("pop without room or item");

  a_sum_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s_valid && !s_ready |=> s_valid && $stable(s_tag))
    else $error("sum stage lost a stalled beat");

  a_product_advances: assert property (@(posedge clk) disable iff (rst)
    p_valid && s_ready |=> s_valid)
    else $error("product stage beat dropped");

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import icf_pkg::*;

  localparam int MAX_W        = DEF_MAX_WIDTH;
  localparam int MAX_H        = DEF_MAX_HEIGHT;
  localparam int LINE_COUNT   = DEF_MAX_TAPS - 1;
  localparam int ROW_W        = $clog2(DEF_MAX_HEIGHT);
  localparam int COL_W        = $clog2(DEF_MAX_WIDTH);
  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT  = 3000;

  typedef struct packed {
    logic signed [SUM_W-1:0] value;
    logic [ROW_W-1:0]        row;
    logic [COL_W-1:0]        column;
    logic                    last;
  } column_sum_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    write_enable = 1'b0;
  cfg_reg_t                register_index = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0]        write_data = '0;
  logic                    pixel_valid = 1'b0;
  logic                    pixel_ready;
  logic signed [PIX_W-1:0] pixel_value = '0;
  logic                    result_valid;
  logic                    result_ready = 1'b0;
  logic signed [SUM_W-1:0] filtered_value;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_column;
  logic                    frame_end;

  image_column_fir_filter_top dut (
    .clk, .rst, .write_enable, .register_index, .write_data,
    .pixel_valid, .pixel_ready, .pixel_value,
    .result_valid, .result_ready, .filtered_value, .out_row, .out_column, .frame_end
  );

  // mirror of the block's state
  logic signed [PIX_W-1:0] line_rows [LINE_COUNT*MAX_W];
  int unsigned             col_cnt = 0;
  int unsigned             row_cnt = 0;
  logic [DIM_W-1:0]        cfg_width = RST_WIDTH;
  logic [DIM_W-1:0]        cfg_height = RST_HEIGHT;
  logic [KSIZE_W-1:0]      cfg_ksize = RST_KSIZE;
  logic [63:0]             cfg_taps_lo = '0;
  logic [TAPS_HI_W-1:0]    cfg_taps_hi = '0;

  column_sum_t expected_sums[$];

  int sender_max_gap = 13;
  int receiver_max_gap = 13;
  int hold_off_cycles = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
  endtask

  function automatic logic signed [COEF_W-1:0] tap_at(int unsigned k);
    if (k < 4) return cfg_taps_lo[16*k +: 16];
    return cfg_taps_hi[16*(k-4) +: 16];
  endfunction

  task automatic predict_column_sum(logic signed [PIX_W-1:0] pix);
    int unsigned w, h, s, col, row, border, src, k;
    longint acc;
    column_sum_t want;
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_W) ? MAX_W : cfg_width);
    h = (cfg_height == 0) ? 1 : ((cfg_height > MAX_H) ? MAX_H : cfg_height);
    s = (cfg_ksize > DEF_MAX_TAPS) ? DEF_MAX_TAPS : cfg_ksize;
    // counts left beyond a shrunk frame wrap first
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    col = col_cnt;
    row = row_cnt;
    if (s >= 1 && row >= s - 1) begin
      border = (s - 1) >> 1;
      acc = longint'(tap_at(s - 1)) * longint'(pix);
      for (k = 0; k + 1 < s; k++) begin
        src = row - (s - 1 - k);
        acc += longint'(tap_at(k)) * longint'(line_rows[(src % LINE_COUNT) * MAX_W + col]);
      end
      want.value  = acc[SUM_W-1:0];
      want.row    = ROW_W'(row - (s - 1 - border));
      want.column = COL_W'(col);
      want.last   = (row == h - 1) && (col == w - 1);
      expected_sums.push_back(want);
    end
    line_rows[(row % LINE_COUNT) * MAX_W + col] = pix;
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = row + 1;
      if (row_cnt >= h) row_cnt = 0;
    end
  endtask

  task automatic send_pixel(logic signed [PIX_W-1:0] pix);
    int gap;
    gap = $urandom_range(sender_max_gap, 0);
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_value <= pix;
    @(posedge clk);
    while (!pixel_ready) @(posedge clk);
    predict_column_sum(pix);
  endtask

  function automatic logic signed [PIX_W-1:0] random_pixel();
    case ($urandom_range(9, 0))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic send_random_pixels(int count);
    int i;
    for (i = 0; i < count; i++) send_pixel(random_pixel());
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_register(cfg_reg_t idx, logic [CFG_W-1:0] data);
    write_enable   <= 1'b1;
    register_index <= idx;
    write_data     <= data;
    @(posedge clk);
  endtask

  // bits above each register's width carry noise; the block must drop them
  task automatic load_settings(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                               logic [KSIZE_W-1:0] ks, logic [63:0] lo,
                               logic [TAPS_HI_W-1:0] hi);
    logic [CFG_W-1:0] word;
    wait_idle();
    word = {$urandom, $urandom};
    word[DIM_W-1:0] = w;
    put_register(REG_IMAGE_WIDTH, word);
    word = {$urandom, $urandom};
    word[DIM_W-1:0] = h;
    put_register(REG_IMAGE_HEIGHT, word);
    word = {$urandom, $urandom};
    word[KSIZE_W-1:0] = ks;
    put_register(REG_KERNEL_SIZE, word);
    put_register(REG_TAPS_LOW, lo);
    put_register(REG_TAPS_HIGH, {16'($urandom), hi});
    write_enable <= 1'b0;
    cfg_width   = w;
    cfg_height  = h;
    cfg_ksize   = ks;
    cfg_taps_lo = lo;
    cfg_taps_hi = hi;
  endtask

  task automatic test_edge_values();
    load_settings(12'd1, 12'd7, 3'd7, {4{16'h8000}}, {3{16'h8000}});
    repeat (7) send_pixel(16'sh8000);
    load_settings(12'd1, 12'd7, 3'd7, {4{16'h7fff}}, {3{16'h7fff}});
    repeat (6) send_pixel(16'sh8000);
    send_pixel(16'sh7fff);
  endtask

  task automatic test_special_sizes();
    // zero kernel size: counts move, no results
    load_settings(12'd2, 12'd2, 3'd0, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_pixels(4);
    // even kernel
    load_settings(12'd1, 12'd5, 3'd4, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_pixels(5);
    // frame shorter than the kernel
    load_settings(12'd2, 12'd3, 3'd5, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_pixels(6);
    // shrink mid-frame so the counts wrap to the next frame
    load_settings(12'd4, 12'd4, 3'd3, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_pixels(11);
    load_settings(12'd2, 12'd2, 3'd1, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_pixels(4);
  endtask

  task automatic test_backpressure();
    sender_max_gap = 0;
    receiver_max_gap = 0;
    load_settings(12'd6, 12'd8, 3'd5, {$urandom, $urandom}, {$urandom, $urandom});
    hold_off_cycles = 400;
    send_random_pixels(48);
    send_random_pixels(30);
    wait_idle();
    send_random_pixels(18);
    sender_max_gap = 13;
    receiver_max_gap = 13;
  endtask

  task automatic test_random_frames();
    int sent, n;
    logic [DIM_W-1:0] w, h;
    sent = 0;
    while (sent < 900) begin
      w = ($urandom_range(7, 0) == 0) ? DIM_W'($urandom_range(64, 17))
                                      : DIM_W'($urandom_range(16, 1));
      h = DIM_W'($urandom_range(12, 1));
      case ($urandom_range(3, 0))
        0: sender_max_gap = 0;
        1: sender_max_gap = 3;
        default: sender_max_gap = 13;
      endcase
      case ($urandom_range(3, 0))
        0: receiver_max_gap = 0;
        1: receiver_max_gap = 3;
        default: receiver_max_gap = 13;
      endcase
      load_settings(w, h, KSIZE_W'($urandom_range(7, 0)),
                    {$urandom, $urandom}, {$urandom, $urandom});
      n = w * h * $urandom_range(2, 1);
      send_random_pixels(n);
      sent += n;
    end
    sender_max_gap = 13;
    receiver_max_gap = 13;
  endtask

  task automatic test_dimension_limits();
    sender_max_gap = 3;
    receiver_max_gap = 3;
    load_settings(12'd0, 12'hfff, 3'd7, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_pixels(64);
    load_settings(12'hfff, 12'd0, 3'd1, {$urandom, $urandom}, {$urandom, $urandom});
    send_random_pixels(64);
    sender_max_gap = 13;
    receiver_max_gap = 13;
  endtask

  initial begin : result_sink
    int stall;
    column_sum_t want;
    wait (!rst);
    forever begin
      stall = (hold_off_cycles > 0) ? hold_off_cycles : $urandom_range(receiver_max_gap, 0);
      hold_off_cycles = 0;
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected result beat", filtered_value, 0);
      end else begin
        want = expected_sums.pop_front();
        if (filtered_value !== want.value)
          report_mismatch("filtered_value", filtered_value, want.value);
        if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
        if (out_column !== want.column)
          report_mismatch("out_column", out_column, want.column);
        if (frame_end !== want.last) report_mismatch("frame_end", frame_end, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_edge_values();
    test_special_sizes();
    test_backpressure();
    test_random_frames();
    test_dimension_limits();
    wait_idle();
    if (mismatch_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/icf_pkg.sv
rtl/core/icf_queue.sv
rtl/core/icf_front.sv
rtl/core/icf_back.sv
rtl/core/image_column_fir_filter_top.sv
tb/sv/testbench.sv
